// ----- design/tkph_pkg.sv -----
// shared types and constants for the two-key priority heap
`timescale 1ns / 1ps
`default_nettype none
package tkph_pkg;
  localparam int unsigned DefCapacity = 64;

  typedef struct packed {
    logic [15:0] svc;
    logic [15:0] arr;
    logic [7:0]  pri;
    logic [15:0] id;
  } slot_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_EX_RD0, S_EX_RDL, S_EX_WR0,
    S_DN_RDL, S_DN_RDR, S_DN_CMP, S_OUT
  } state_t;

  // a outranks b: higher priority, then earlier arrival, then smaller id
  function automatic logic outranks(input slot_t a, input slot_t b);
    if (a.pri != b.pri) return a.pri > b.pri;
    if (a.arr != b.arr) return a.arr < b.arr;
    return a.id < b.id;
  endfunction
endpackage
`default_nettype wire

// ----- design/two_key_priority_heap.sv -----
// top level of the two-key priority heap: memory plus sift sequencer
//
// Input channel in_*: one transaction is one operation. in_tuser is op (0 insert,
// 1 extract); in_tdata packs entry_id, priority_level, arrival_time, service_time.
// Output channel out_*: exactly one result transaction per operation, with
// status in out_tuser and extracted entry plus occupancy in out_tdata.
// Operations are handled one at a time. The heap lives in a synchronous memory
// with one write and one read port and a registered read. An insert into an empty
// heap is written straight away; other inserts read the parent and compare for
// each level climbed, and an extract reads the root and the last entry, then reads
// the left and right children and compares for each level descended, climbing or
// descending up to log2(CAPACITY) levels (six at 64 entries).
// Refused operations raise out_tvalid in the cycle after acceptance.
// A synchronous active-low reset empties the heap; memory contents are left
// undefined and entries past the fill count are never used.
// The result sits in an output register; while the receiver stalls it holds,
// and in_tready stays low until the result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module two_key_priority_heap #(
  parameter int unsigned CAPACITY = tkph_pkg::DefCapacity
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,  // entry_id, priority_level, arrival_time, service_time
  input  wire         in_tuser,  // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata, // out_id, out_priority, out_arrival, out_service,
                                 // occupancy, zero fill
  output logic [1:0]  out_tuser  // status
);
  import tkph_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  slot_t mem [CAPACITY];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  slot_t         mem_wd, mem_rd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd <= mem[mem_ra];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt, par_r, par_nxt;
  slot_t cur_r, cur_nxt, a_r, a_nxt, res_r, res_nxt;
  logic  has_r_r, has_r_nxt;
  status_t st_r, st_nxt;

  logic [CW:0]   left_w, right_w;
  assign left_w  = (CW+1)'({pos_r, 1'b1});
  assign right_w = left_w + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r <= pos_nxt; par_r <= par_nxt; cur_r <= cur_nxt; a_r <= a_nxt;
    res_r <= res_nxt; has_r_r <= has_r_nxt; st_r <= st_nxt;
  end

  always_comb begin
    slot_t best;
    logic [AW-1:0] bidx;
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; par_nxt = par_r;
    cur_nxt = cur_r; a_nxt = a_r; res_nxt = res_r; has_r_nxt = has_r_r; st_nxt = st_r;
    mem_we = 1'b0; mem_wa = pos_r; mem_wd = cur_r; mem_ra = par_r;
    in_tready = (state_r == S_IDLE);
    best = cur_r; bidx = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_nxt = '0;
          st_nxt  = ST_DONE;
          if (!in_tuser) begin
            if (cnt_r >= CW'(CAPACITY)) begin
              st_nxt = ST_FULL; state_nxt = S_OUT;
            end else begin
              cur_nxt = slot_t'(in_tdata);
              pos_nxt = cnt_r[AW-1:0];
              par_nxt = AW'((cnt_r - 1'b1) >> 1);
              mem_ra  = AW'((cnt_r - 1'b1) >> 1);
              cnt_nxt = cnt_r + 1'b1;
              state_nxt = (cnt_r == '0) ? S_UP_CMP : S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              st_nxt = ST_EMPTY; state_nxt = S_OUT;
            end else begin
              mem_ra = '0; state_nxt = S_EX_RD0;
            end
          end
        end
      end
      S_UP_RD: state_nxt = S_UP_CMP; // parent data arrives
      S_UP_CMP: begin
        if (pos_r != '0 && outranks(cur_r, mem_rd)) begin
          mem_we = 1'b1; mem_wa = pos_r; mem_wd = mem_rd;
          pos_nxt = par_r;
          par_nxt = AW'((par_r - 1'b1) >> 1);
          mem_ra  = AW'((par_r - 1'b1) >> 1);
          state_nxt = (par_r == '0) ? S_UP_CMP : S_UP_RD;
        end else begin
          mem_we = 1'b1; state_nxt = S_OUT;
        end
      end
      S_EX_RD0: begin
        // root arrives, fetch the last entry next
        res_nxt = mem_rd;
        mem_ra = AW'(cnt_r - 1'b1);
        state_nxt = S_EX_RDL;
      end
      S_EX_RDL: begin
        cur_nxt = mem_rd; pos_nxt = '0;
        cnt_nxt = cnt_r - 1'b1;
        state_nxt = S_EX_WR0;
      end
      S_EX_WR0: begin
        state_nxt = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_w >= (CW+1)'(cnt_r)) begin
          mem_we = 1'b1; state_nxt = S_OUT;
        end else begin
          mem_ra = left_w[AW-1:0]; state_nxt = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        mem_ra = right_w[AW-1:0];
        has_r_nxt = right_w < (CW+1)'(cnt_r);
        state_nxt = S_DN_CMP;
        a_nxt = mem_rd;
      end
      S_DN_CMP: begin
        if (outranks(a_r, best)) begin best = a_r; bidx = left_w[AW-1:0]; end
        if (has_r_r && outranks(mem_rd, best)) begin
          best = mem_rd; bidx = right_w[AW-1:0];
        end
        if (bidx == pos_r) begin
          mem_we = 1'b1; state_nxt = S_OUT;
        end else begin
          mem_we = 1'b1; mem_wa = pos_r; mem_wd = best;
          pos_nxt = bidx; state_nxt = S_DN_RDL;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = st_r;
  assign out_tdata  = {1'b0, 7'(cnt_r), res_r.svc, res_r.arr, res_r.pri, res_r.id};

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("count above capacity");
  a_ready_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |=> $stable(cnt_r)) else $error("count moved at output");
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_DONE) |-> res_r == '0)
    else $error("refused op returns entry");
endmodule
`default_nettype wire
